// ===== hdl/sh24_pkg.sv =====
// Shared types, constants and functions of the SipHash-2-4 stream unit.
`timescale 1ns / 1ps

package sh24_pkg;

  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [63:0] FIN_XOR = 64'h00000000000000ff;

  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  localparam logic [2:0] BLK_LAST_STEP = 3'd3;
  localparam logic [2:0] FIN_LAST_STEP = 3'd7;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_state_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_BLK  = 5'b00010,
    ST_FINC = 5'b00100,
    ST_FINR = 5'b01000,
    ST_DONE = 5'b10000
  } sh24_state_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int n);
    rotl = (x << n) | (x >> (64 - n));
  endfunction

  function automatic sip_state_t key_init(input logic [63:0] k0, input logic [63:0] k1);
    sip_state_t s;
    s.v0 = SIP_C0 ^ k0;
    s.v1 = SIP_C1 ^ k1;
    s.v2 = SIP_C2 ^ k0;
    s.v3 = SIP_C3 ^ k1;
    key_init = s;
  endfunction

endpackage

// ===== hdl/sh24_half_round.sv =====
// Shared half SipRound unit: two 64-bit adds with their rotates and XORs.
`timescale 1ns / 1ps

module sh24_half_round (
  input  logic                 phase,
  input  sh24_pkg::sip_state_t v_in,
  output sh24_pkg::sip_state_t v_out
);

  logic [63:0] sum_a;
  logic [63:0] sum_b;

  always_comb begin
    if (!phase) begin
      sum_a       = v_in.v0 + v_in.v1;
      sum_b       = v_in.v2 + v_in.v3;
      v_out.v0    = sh24_pkg::rotl(sum_a, 32);
      v_out.v1    = sh24_pkg::rotl(v_in.v1, 13) ^ sum_a;
      v_out.v2    = sum_b;
      v_out.v3    = sh24_pkg::rotl(v_in.v3, 16) ^ sum_b;
    end else begin
      sum_a       = v_in.v0 + v_in.v3;
      sum_b       = v_in.v2 + v_in.v1;
      v_out.v0    = sum_a;
      v_out.v1    = sh24_pkg::rotl(v_in.v1, 17) ^ sum_b;
      v_out.v2    = sh24_pkg::rotl(sum_b, 32);
      v_out.v3    = sh24_pkg::rotl(v_in.v3, 21) ^ sum_a;
    end
  end

endmodule

// ===== hdl/siphash_2_4_stream_unit.sv =====
// Top level: byte packing, round sequencer, key registers and result register.
// An item without a block end or last is taken in ST_IDLE; a block end runs ST_BLK (two
// SipRounds as four half rounds on the shared unit); last adds ST_FINC, ST_FINR, ST_DONE.
// Throughput: 1 item per cycle between block ends while cfg_valid is low.
// Reset: rst_n clears both keys to zero and loads the state from the zero key.
`timescale 1ns / 1ps

module siphash_2_4_stream_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] hash_value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  sh24_pkg::sh24_state_t state_r, state_nxt;
  sh24_pkg::sip_state_t  v_r, v_nxt, hr_out;
  logic [63:0] key_lo_r, key_lo_nxt;
  logic [63:0] key_hi_r, key_hi_nxt;
  logic [55:0] pend_r, pend_nxt;
  logic [7:0]  total_r, total_nxt;
  logic [63:0] msg_r, msg_nxt;
  logic        fin_r, fin_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic [55:0] pend_add;
  logic [63:0] word;
  logic [63:0] fmsg;
  logic        in_acc;

  sh24_half_round u_half_round (
    .phase (cnt_r[0]),
    .v_in  (v_r),
    .v_out (hr_out)
  );

  assign cfg_ready  = (state_r == sh24_pkg::ST_IDLE);
  assign in_tready  = (state_r == sh24_pkg::ST_IDLE) && !cfg_valid;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    pend_add = pend_r;
    for (int i = 0; i < 7; i++) begin
      if (total_r[2:0] == 3'(i)) begin
        pend_add[8*i +: 8] = in_tdata;
      end
    end
    word = {in_tdata, pend_r};
  end

  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    key_lo_nxt    = key_lo_r;
    key_hi_nxt    = key_hi_r;
    pend_nxt      = pend_r;
    total_nxt     = total_r;
    msg_nxt       = msg_r;
    fin_nxt       = fin_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    fmsg          = {total_r, pend_r};

    unique case (state_r)
      sh24_pkg::ST_IDLE: begin
        if (cfg_valid) begin
          if (cfg_index == sh24_pkg::CFG_KEY_LOW) begin
            key_lo_nxt = cfg_data;
            v_nxt      = sh24_pkg::key_init(cfg_data, key_hi_r);
          end else begin
            key_hi_nxt = cfg_data;
            v_nxt      = sh24_pkg::key_init(key_lo_r, cfg_data);
          end
          pend_nxt  = '0;
          total_nxt = '0;
        end else if (in_acc) begin
          cnt_nxt = '0;
          fin_nxt = in_tlast;
          if (in_tuser) begin
            total_nxt = total_r + 8'd1;
          end
          if (in_tuser && (total_r[2:0] == 3'd7)) begin
            pend_nxt  = '0;
            msg_nxt   = word;
            v_nxt.v3  = v_r.v3 ^ word;
            state_nxt = sh24_pkg::ST_BLK;
          end else begin
            if (in_tuser) begin
              pend_nxt = pend_add;
            end
            if (in_tlast) begin
              msg_nxt   = {total_nxt, pend_nxt};
              v_nxt.v3  = v_r.v3 ^ {total_nxt, pend_nxt};
              state_nxt = sh24_pkg::ST_FINC;
            end
          end
        end
      end
      sh24_pkg::ST_BLK: begin
        v_nxt   = hr_out;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == sh24_pkg::BLK_LAST_STEP) begin
          v_nxt.v0 = hr_out.v0 ^ msg_r;
          cnt_nxt  = '0;
          if (fin_r) begin
            msg_nxt   = fmsg;
            v_nxt.v3  = hr_out.v3 ^ fmsg;
            state_nxt = sh24_pkg::ST_FINC;
          end else begin
            state_nxt = sh24_pkg::ST_IDLE;
          end
        end
      end
      sh24_pkg::ST_FINC: begin
        v_nxt   = hr_out;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == sh24_pkg::BLK_LAST_STEP) begin
          v_nxt.v0  = hr_out.v0 ^ msg_r;
          v_nxt.v2  = hr_out.v2 ^ sh24_pkg::FIN_XOR;
          cnt_nxt   = '0;
          state_nxt = sh24_pkg::ST_FINR;
        end
      end
      sh24_pkg::ST_FINR: begin
        v_nxt   = hr_out;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == sh24_pkg::FIN_LAST_STEP) begin
          cnt_nxt   = '0;
          state_nxt = sh24_pkg::ST_DONE;
        end
      end
      sh24_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = v_r.v0 ^ v_r.v1 ^ v_r.v2 ^ v_r.v3;
          v_nxt         = sh24_pkg::key_init(key_lo_r, key_hi_r);
          pend_nxt      = '0;
          total_nxt     = '0;
          state_nxt     = sh24_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sh24_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sh24_pkg::ST_IDLE;
      v_r         <= sh24_pkg::key_init(64'd0, 64'd0);
      key_lo_r    <= '0;
      key_hi_r    <= '0;
      pend_r      <= '0;
      total_r     <= '0;
      fin_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      v_r         <= v_nxt;
      key_lo_r    <= key_lo_nxt;
      key_hi_r    <= key_hi_nxt;
      pend_r      <= pend_nxt;
      total_r     <= total_nxt;
      fin_r       <= fin_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msg_r      <= msg_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
